@@ hw/rtl/jsu_pkg.sv @@
// Shared types, result codes and the UTF-8 encoder for the JSON string unescaper.
package jsu_pkg;

    localparam int unsigned MaxResults = 4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_END_OF_INPUT = 2'd0;
    localparam logic [1:0] ERR_CONTROL      = 2'd1;
    localparam logic [1:0] ERR_BAD_HEX      = 2'd2;
    localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] error_code;
        logic       last;
    } t_out_item;

    // All results caused by one input beat, in delivery order.
    typedef struct packed {
        logic [2:0]                      count;
        t_out_item [MaxResults-1:0]      items;
    } t_group;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } t_utf8;

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp < 21'h80) begin
            r.len      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/jsu_decode.sv @@
// Input register, escape state machine and per-beat result group builder.
module jsu_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  jsu_pkg::t_in_item i_in_beat,
    output logic              o_grp_valid,
    input  logic              i_grp_stall,
    output jsu_pkg::t_group   o_grp
);

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESCAPE = 3'd1;
    localparam logic [2:0] MODE_HEX0   = 3'd2;
    localparam logic [2:0] MODE_HEX3   = 3'd5;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= "0" && c <= "9") begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end else if (c >= "a" && c <= "f") begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end else if (c >= "A" && c <= "F") begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    logic              r_in_valid;
    jsu_pkg::t_in_item r_in;
    logic [2:0]        r_mode;
    logic [11:0]       r_hex;
    logic [15:0]       r_held;
    logic              r_held_valid;
    logic [2:0]        n_mode;
    logic [11:0]       n_hex;
    logic [15:0]       n_held;
    logic              n_held_valid;

    logic              leave;
    logic [4:0]        hd;
    logic [15:0]       cp16;
    logic [20:0]       src_cp;
    logic              src_on;
    logic              tail_on;
    jsu_pkg::t_out_item tail;
    jsu_pkg::t_utf8    enc;
    logic [2:0]        flen;
    logic [2:0]        count;
    logic [7:0]        c;
    logic              eoi;
    logic              pair;

    assign c    = r_in.in_byte;
    assign eoi  = r_in.end_of_input;
    assign hd   = hex_digit(c);
    assign cp16 = {r_hex, hd[3:0]};
    assign pair = r_held_valid && r_held >= 16'hD800 && r_held <= 16'hDBFF
                  && cp16 >= 16'hDC00 && cp16 <= 16'hDFFF;

    always_comb begin
        n_mode       = r_mode;
        n_hex        = r_hex;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        src_cp       = {5'd0, r_held};
        src_on       = 1'b0;
        tail_on      = 1'b0;
        tail         = '0;
        priority if (r_mode >= MODE_HEX0 && r_mode <= MODE_HEX3) begin
            if (eoi || !hd[4]) begin
                tail_on          = 1'b1;
                tail.kind        = jsu_pkg::KIND_ERROR;
                tail.error_code  = jsu_pkg::ERR_BAD_HEX;
                n_mode           = MODE_NORMAL;
                n_hex            = '0;
                n_held           = '0;
                n_held_valid     = 1'b0;
            end else if (r_mode != MODE_HEX3) begin
                n_hex  = cp16[11:0];
                n_mode = r_mode + 3'd1;
            end else begin
                n_hex  = '0;
                n_mode = MODE_NORMAL;
                if (pair) begin
                    // Lead and trail surrogate combine into one supplementary character.
                    src_cp       = {1'b0, r_held[9:0], cp16[9:0]} + 21'h10000;
                    src_on       = 1'b1;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                end else begin
                    src_on       = r_held_valid;
                    n_held       = cp16;
                    n_held_valid = 1'b1;
                end
            end
        end else if (r_mode == MODE_ESCAPE) begin
            tail_on = 1'b1;
            n_mode  = MODE_NORMAL;
            if (eoi) begin
                tail.kind       = jsu_pkg::KIND_ERROR;
                tail.error_code = jsu_pkg::ERR_END_OF_INPUT;
                n_held          = '0;
                n_held_valid    = 1'b0;
                n_hex           = '0;
            end else if (c == "u") begin
                tail_on = 1'b0;
                n_mode  = MODE_HEX0;
                n_hex   = '0;
            end else begin
                unique case (c)
                    "b":           tail.out_byte = 8'h08;
                    "f":           tail.out_byte = 8'h0C;
                    "n":           tail.out_byte = 8'h0A;
                    "r":           tail.out_byte = 8'h0D;
                    "t":           tail.out_byte = 8'h09;
                    "\"", "\\", "/": tail.out_byte = c;
                    default: begin
                        tail.kind       = jsu_pkg::KIND_ERROR;
                        tail.error_code = jsu_pkg::ERR_BAD_ESCAPE;
                    end
                endcase
                if (tail.kind == jsu_pkg::KIND_ERROR) begin
                    n_held       = '0;
                    n_held_valid = 1'b0;
                    n_hex        = '0;
                end else begin
                    src_on       = r_held_valid;
                    n_held       = '0;
                    n_held_valid = 1'b0;
                end
            end
        end else begin
            // Normal mode; the unused codes behave the same way.
            n_mode  = MODE_NORMAL;
            tail_on = 1'b1;
            if (eoi || (c <= 8'h1F && c != "\"")) begin
                tail.kind       = jsu_pkg::KIND_ERROR;
                tail.error_code = eoi ? jsu_pkg::ERR_END_OF_INPUT : jsu_pkg::ERR_CONTROL;
                n_held          = '0;
                n_held_valid    = 1'b0;
                n_hex           = '0;
            end else if (c == "\"") begin
                tail.kind    = jsu_pkg::KIND_CLOSE;
                src_on       = r_held_valid;
                n_held       = '0;
                n_held_valid = 1'b0;
                n_hex        = '0;
            end else if (c == "\\") begin
                tail_on = 1'b0;
                n_mode  = MODE_ESCAPE;
            end else begin
                tail.out_byte = c;
                src_on        = r_held_valid;
                n_held        = '0;
                n_held_valid  = 1'b0;
            end
        end
    end

    assign enc   = jsu_pkg::utf8_encode(src_cp);
    assign flen  = src_on ? enc.len : 3'd0;
    assign count = flen + {2'd0, tail_on};

    always_comb begin
        o_grp       = '0;
        o_grp.count = count;
        for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
            if (3'(i) < flen) begin
                o_grp.items[i].kind     = jsu_pkg::KIND_BYTE;
                o_grp.items[i].out_byte = enc.bytes[i];
            end else begin
                o_grp.items[i] = tail;
            end
            o_grp.items[i].last = (3'(i) == count - 3'd1);
        end
    end

    assign o_grp_valid = r_in_valid && (count != 3'd0);
    assign leave       = r_in_valid && ((count == 3'd0) || !i_grp_stall);
    assign o_in_stall  = r_in_valid && !leave;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_mode       <= MODE_NORMAL;
            r_hex        <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (leave) begin
                r_mode       <= n_mode;
                r_hex        <= n_hex;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_beat;
        end
    end

endmodule

@@ hw/rtl/jsu_serial.sv @@
// Result group register that hands out one result beat per cycle while the output is not stalled.
module jsu_serial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_grp_valid,
    output logic               o_grp_stall,
    input  jsu_pkg::t_group    i_grp,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jsu_pkg::t_out_item o_out_beat
);

    logic            r_valid;
    jsu_pkg::t_group r_grp;
    logic [1:0]      r_idx;
    logic            take;
    logic            take_last;
    logic            load;

    assign take        = r_valid && !i_out_stall;
    assign take_last   = take && ({1'b0, r_idx} == r_grp.count - 3'd1);
    assign o_grp_stall = r_valid && !take_last;
    assign load        = i_grp_valid && !o_grp_stall;

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_grp.items[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take_last) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_grp <= i_grp;
        end
    end

endmodule

@@ hw/rtl/json_string_unescaper_top.sv @@
// Top level of the JSON string body unescaper.
// Takes the raw bytes of a JSON string body, one per input beat, starting after the
// opening quote, and delivers decoded bytes, a close marker or an error, one per output
// beat; the final result of each input beat carries last. An input beat is registered,
// decoded into a group of zero to four results, and the group is handed to an output
// register that delivers one result per cycle while the output is not stalled. A group
// of several results (a flushed multi-byte UTF-8 character) keeps that single register
// busy, so the next input beat waits in the input register until its last result is
// taken. A \u value is held until the next decoded result or the closing quote, so its
// bytes appear on that later beat; an error drops it. After a close or an error all
// state returns to the start of a new string body.
module json_string_unescaper_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jsu_pkg::t_in_item  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jsu_pkg::t_out_item o_out_beat
);

    logic            grp_valid;
    logic            grp_stall;
    jsu_pkg::t_group grp;

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_grp_valid (grp_valid),
        .i_grp_stall (grp_stall),
        .o_grp       (grp)
    );

    jsu_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .o_grp_stall (grp_stall),
        .i_grp       (grp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

@@ test/json_string_unescaper_top_tb.sv @@
// Self-checking testbench for the JSON string unescaper: directed and random byte streams.
`timescale 1ns / 100ps

module json_string_unescaper_top_tb;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TAIL_CYCLES     = 20;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_ITEMS    = 410;

    localparam logic [2:0] MODE_TEXT = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_HEX1 = 3'd2;
    localparam logic [2:0] MODE_HEX4 = 3'd5;

    localparam logic [1:0] NO_ERROR = 2'd0;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_B      = "b";
    localparam logic [7:0] CH_F      = "f";
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_R      = "r";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_U      = "u";

    localparam int RX_FREE     = 0;
    localparam int RX_LIGHT    = 1;
    localparam int RX_HEAVY    = 2;
    localparam int RX_PERIODIC = 3;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    jsu_pkg::t_in_item  in_beat   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    jsu_pkg::t_out_item out_beat;

    // Unescaper state as seen by the predictor.
    logic [2:0]  dec_mode = MODE_TEXT;
    logic [15:0] hex_acc  = '0;
    logic [15:0] held_cp  = '0;
    logic        held_vld = 1'b0;

    jsu_pkg::t_out_item beat_results[$];
    jsu_pkg::t_out_item expected_out[$];

    int  fail_count    = 0;
    int  items_sent    = 0;
    int  burst_left    = 0;
    bit  sender_gaps   = 1'b1;
    bit  hold_off_req  = 1'b0;
    int  cycle_count   = 0;

    json_string_unescaper_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic jsu_pkg::t_in_item make_beat(input logic [7:0] b, input logic eoi);
        jsu_pkg::t_in_item it;
        it.in_byte      = b;
        it.end_of_input = eoi;
        return it;
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] value,
                        input logic [1:0] code);
        jsu_pkg::t_out_item r;
        r.kind       = kind;
        r.out_byte   = value;
        r.error_code = code;
        r.last       = 1'b0;
        beat_results.insert(beat_results.size(), r);
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(jsu_pkg::KIND_BYTE, cp[7:0], NO_ERROR);
        end else if (cp < 21'h800) begin
            emit(jsu_pkg::KIND_BYTE, 8'hC0 | {3'd0, cp[10:6]}, NO_ERROR);
            emit(jsu_pkg::KIND_BYTE, 8'h80 | {2'd0, cp[5:0]}, NO_ERROR);
        end else if (cp < 21'h10000) begin
            emit(jsu_pkg::KIND_BYTE, 8'hE0 | {4'd0, cp[15:12]}, NO_ERROR);
            emit(jsu_pkg::KIND_BYTE, 8'h80 | {2'd0, cp[11:6]}, NO_ERROR);
            emit(jsu_pkg::KIND_BYTE, 8'h80 | {2'd0, cp[5:0]}, NO_ERROR);
        end else begin
            emit(jsu_pkg::KIND_BYTE, 8'hF0 | {5'd0, cp[20:18]}, NO_ERROR);
            emit(jsu_pkg::KIND_BYTE, 8'h80 | {2'd0, cp[17:12]}, NO_ERROR);
            emit(jsu_pkg::KIND_BYTE, 8'h80 | {2'd0, cp[11:6]}, NO_ERROR);
            emit(jsu_pkg::KIND_BYTE, 8'h80 | {2'd0, cp[5:0]}, NO_ERROR);
        end
    endtask

    task automatic release_held();
        if (held_vld) emit_utf8({5'd0, held_cp});
        held_vld = 1'b0;
        held_cp  = '0;
    endtask

    task automatic clear_state();
        dec_mode = MODE_TEXT;
        hex_acc  = '0;
        held_cp  = '0;
        held_vld = 1'b0;
    endtask

    // An error drops any held value and leaves a single error result.
    task automatic abort_string(input logic [1:0] code);
        clear_state();
        beat_results.delete();
        emit(jsu_pkg::KIND_ERROR, 8'h00, code);
    endtask

    task automatic decode_beat(input jsu_pkg::t_in_item it);
        logic [7:0]  c;
        logic        eoi;
        int          d;
        logic [15:0] cp;
        logic [20:0] full;
        logic [7:0]  b;
        bit          known;
        c   = it.in_byte;
        eoi = it.end_of_input;
        beat_results.delete();
        if (dec_mode >= MODE_HEX1 && dec_mode <= MODE_HEX4) begin
            d = hex_digit_value(c);
            if (eoi || d < 0) begin
                abort_string(jsu_pkg::ERR_BAD_HEX);
            end else begin
                cp = {hex_acc[11:0], 4'(d)};
                if (dec_mode != MODE_HEX4) begin
                    hex_acc  = cp;
                    dec_mode = dec_mode + 3'd1;
                end else begin
                    hex_acc  = '0;
                    dec_mode = MODE_TEXT;
                    if (held_vld && held_cp >= 16'hD800 && held_cp <= 16'hDBFF
                        && cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                        // Both surrogates are 1 KiB aligned, so the offsets are the low bits.
                        full     = 21'h10000 + {1'b0, held_cp[9:0], cp[9:0]};
                        held_vld = 1'b0;
                        held_cp  = '0;
                        emit_utf8(full);
                    end else begin
                        release_held();
                        held_cp  = cp;
                        held_vld = 1'b1;
                    end
                end
            end
        end else if (dec_mode == MODE_ESC) begin
            if (eoi) begin
                abort_string(jsu_pkg::ERR_END_OF_INPUT);
            end else if (c == CH_U) begin
                dec_mode = MODE_HEX1;
                hex_acc  = '0;
            end else begin
                known = 1'b1;
                b     = c;
                case (c)
                    CH_B: b = 8'h08;
                    CH_F: b = 8'h0C;
                    CH_N: b = 8'h0A;
                    CH_R: b = 8'h0D;
                    CH_T: b = 8'h09;
                    CH_QUOTE, CH_BSLASH, CH_SLASH: b = c;
                    default: known = 1'b0;
                endcase
                if (!known) begin
                    abort_string(jsu_pkg::ERR_BAD_ESCAPE);
                end else begin
                    dec_mode = MODE_TEXT;
                    release_held();
                    emit(jsu_pkg::KIND_BYTE, b, NO_ERROR);
                end
            end
        end else begin
            dec_mode = MODE_TEXT;
            if (eoi) begin
                abort_string(jsu_pkg::ERR_END_OF_INPUT);
            end else if (c == CH_QUOTE) begin
                release_held();
                emit(jsu_pkg::KIND_CLOSE, 8'h00, NO_ERROR);
                clear_state();
            end else if (c <= 8'h1F) begin
                abort_string(jsu_pkg::ERR_CONTROL);
            end else if (c == CH_BSLASH) begin
                dec_mode = MODE_ESC;
            end else begin
                release_held();
                emit(jsu_pkg::KIND_BYTE, c, NO_ERROR);
            end
        end
        if (beat_results.size() > 0) beat_results[$].last = 1'b1;
        foreach (beat_results[i]) expected_out.insert(expected_out.size(), beat_results[i]);
    endtask

    task automatic check_result(input jsu_pkg::t_out_item got);
        jsu_pkg::t_out_item want;
        if (expected_out.size() == 0) begin
            note_failure($sformatf("unexpected result: kind %0d byte %02h code %0d last %0b",
                                   got.kind, got.out_byte, got.error_code, got.last));
        end else begin
            want = expected_out.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte
                || got.error_code !== want.error_code || got.last !== want.last) begin
                note_failure($sformatf({"result mismatch: expected kind %0d byte %02h ",
                                        "code %0d last %0b, got kind %0d byte %02h ",
                                        "code %0d last %0b"},
                                       want.kind, want.out_byte, want.error_code, want.last,
                                       got.kind, got.out_byte, got.error_code, got.last));
            end
        end
    endtask

    // Prediction runs before checking so both sides see the same edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) decode_beat(in_beat);
            if (out_valid && !out_stall) check_result(out_beat);
        end
    end

    // Receiver stall pattern; a requested hold-off overrides it.
    initial begin : rx_pattern
        int phase_left;
        int style;
        int tick;
        int hold_left;
        phase_left = 0;
        style      = RX_FREE;
        tick       = 0;
        hold_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (phase_left == 0) begin
                    style      = $urandom_range(RX_FREE, RX_PERIODIC);
                    phase_left = $urandom_range(20, 150);
                end
                phase_left--;
                tick++;
                case (style)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
                    default:  out_stall <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    task automatic send_item(input jsu_pkg::t_in_item it);
        if (burst_left == 0) begin
            if (sender_gaps) begin
                repeat ($urandom_range(1, 5)) begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= it;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(make_beat(s[i], 1'b0));
    endtask

    task automatic send_end_of_input();
        send_item(make_beat(8'($urandom), 1'b1));
    endtask

    // A \u escape; when broken, one digit is replaced by a non-hex byte or end of input.
    task automatic send_unicode_escape(input logic [15:0] cp, input bit broken);
        int bad_at;
        logic [7:0] b;
        bad_at = broken ? $urandom_range(0, 3) : 4;
        send_text("\\u");
        for (int k = 0; k < 4; k++) begin
            if (k == bad_at) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_end_of_input();
                end else begin
                    do b = 8'($urandom); while (hex_digit_value(b) >= 0);
                    send_item(make_beat(b, 1'b0));
                end
                return;
            end
            send_item(make_beat(hex_char(cp[15-4*k -: 4], 1'($urandom_range(0, 1))),
                                1'b0));
        end
    endtask

    function automatic logic [15:0] pick_codepoint();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 'h7F));
            1: return 16'($urandom_range('h80, 'h7FF));
            2: return 16'($urandom_range('h800, 'hFFFF));
            3: return 16'($urandom_range('hD800, 'hDBFF));
            4: return 16'($urandom_range('hDC00, 'hDFFF));
            default: begin
                case ($urandom_range(0, 7))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    5: return 16'hD7FF;
                    6: return 16'hE000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // Mostly well-formed string content, with some noise and broken escapes.
    task automatic send_random_segment();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            do b = 8'($urandom_range('h20, 'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
            send_item(make_beat(b, 1'b0));
        end else if (pick < 52) begin
            case ($urandom_range(0, 7))
                0: b = CH_B;
                1: b = CH_F;
                2: b = CH_N;
                3: b = CH_R;
                4: b = CH_T;
                5: b = CH_QUOTE;
                6: b = CH_BSLASH;
                default: b = CH_SLASH;
            endcase
            send_item(make_beat(CH_BSLASH, 1'b0));
            send_item(make_beat(b, 1'b0));
        end else if (pick < 68) begin
            send_unicode_escape(pick_codepoint(), 1'b0);
        end else if (pick < 77) begin
            send_unicode_escape(16'($urandom_range('hD800, 'hDBFF)), 1'b0);
            send_unicode_escape(16'($urandom_range('hDC00, 'hDFFF)), 1'b0);
        end else if (pick < 87) begin
            send_item(make_beat(CH_QUOTE, 1'b0));
        end else begin
            case ($urandom_range(0, 4))
                0: send_item(make_beat(8'($urandom_range(0, 'h1F)), 1'b0));
                1: send_end_of_input();
                2: begin
                    do b = 8'($urandom);
                    while (b inside {CH_B, CH_F, CH_N, CH_R, CH_T, CH_U,
                                     CH_QUOTE, CH_BSLASH, CH_SLASH});
                    send_item(make_beat(CH_BSLASH, 1'b0));
                    send_item(make_beat(b, 1'b0));
                end
                3: send_unicode_escape(pick_codepoint(), 1'b1);
                default: send_item(make_beat(8'($urandom), 1'b0));
            endcase
        end
    endtask

    task automatic test_plain_bytes();
        send_item(make_beat(8'h20, 1'b0));
        send_item(make_beat(8'h7F, 1'b0));
        send_item(make_beat(8'h80, 1'b0));
        send_item(make_beat(8'hFF, 1'b0));
    endtask

    task automatic test_simple_escapes();
        send_text("\\b\\f\\n\\r\\t\\\"\\\\\\/");
    endtask

    task automatic test_unicode();
        // A surrogate pair, then a lone trail surrogate that the close flushes.
        send_text("\\uD83D\\ude00");
        send_text("\\uDC00\"");
    endtask

    task automatic test_errors();
        send_text("\\u00e9");
        send_item(make_beat(8'h00, 1'b0));
        send_text("\\");
        send_end_of_input();
        send_text("\\x");
        send_text("\\u1");
        send_end_of_input();
        send_end_of_input();
    endtask

    task automatic test_backpressure();
        // The receiver holds off while beats keep coming back to back.
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        repeat (16) send_random_segment();
        sender_gaps  = 1'b1;
    endtask

    task automatic test_random_strings();
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) sender_gaps = !sender_gaps;
            send_random_segment();
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_plain_bytes();
        test_simple_escapes();
        test_unicode();
        test_errors();
        test_backpressure();
        test_random_strings();

        @(negedge clk);
        in_valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_out.size() > 0; n++) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_out.size() > 0) begin
            note_failure($sformatf("%0d expected results never arrived", expected_out.size()));
        end
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
